// ===== rtl/gssf_pkg.sv =====
// package for the gain-scheduled state-feedback block
// sizes, register codes and sequencer states; no dependencies

package gssf_pkg;

    localparam int NUM_ACT     = 2;
    localparam int ERR_LEN     = 4;
    localparam int NODE_WORDS  = 10;
    localparam int GAIN_DEPTH  = 2560;
    localparam int MAX_POINTS  = 16;
    localparam int DIV_BITS    = 52;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_MEAS  = 1'b1;

    localparam logic [1:0] FLD_MIN    = 2'd0;
    localparam logic [1:0] FLD_MAX    = 2'd1;
    localparam logic [1:0] FLD_POINTS = 2'd2;
    localparam logic [1:0] FLD_JOINT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS,
        ST_DIV,
        ST_DIVEND,
        ST_WGT,
        ST_BASE,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_TMUL,
        ST_TACC,
        ST_TFIN
    } state_t;

endpackage

// ===== rtl/gain_scheduled_state_feedback_top.sv =====
// a step starts at the last-joint beat: per axis a setup, a bit-serial division of the 52-bit
// dividend and an end step (an axis with max <= min skips its division); then for each of the
// four corners a weight and ten multiply-accumulates; per torque beat a multiply-accumulate per
// error word and a final step; one item at a time through a single shared 33x33 multiplier
// table writes and other measurement beats are taken only while idle, and stall while busy
// reset (async, active low) clears control, error vector and registers; table is undefined
// depends on gssf_pkg

module gain_scheduled_state_feedback_top
    import gssf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [11:0]        table_address,
    input  logic signed [31:0] table_value,
    input  logic               joint_index,
    input  logic signed [31:0] joint_position,
    input  logic signed [31:0] joint_velocity,
    input  logic signed [31:0] ref_position,
    input  logic signed [31:0] ref_velocity,
    input  logic               last_joint,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               actuator_index,
    output logic signed [31:0] torque,
    output logic signed [31:0] envelope_margin,
    output logic               in_envelope,
    output logic               last_actuator
);

    state_t state_reg, state_next;

    logic signed [31:0] axis_min_reg [2];
    logic signed [31:0] axis_max_reg [2];
    logic [4:0]         axis_pts_reg [2];
    logic               axis_jnt_reg [2];
    logic signed [31:0] err_reg [ERR_LEN];
    logic signed [31:0] sched_reg [2];

    logic signed [31:0] gain_mem [GAIN_DEPTH];
    logic signed [31:0] rdata_reg;

    logic               axis_reg;
    logic [5:0]         cnt_reg;
    logic [51:0]        dvd_reg;
    logic [31:0]        den_reg;
    logic [31:0]        rem_reg;
    logic [19:0]        q_reg;
    logic [3:0]         lo_reg [2];
    logic [16:0]        frac_reg [2];
    logic [4:0]         npts_reg [2];
    logic signed [32:0] margin_reg;

    logic [1:0]         corner_reg;
    logic [3:0]         word_reg;
    logic [16:0]        w_reg;
    logic [11:0]        base_reg;
    logic signed [50:0] acc_reg [NODE_WORDS];
    logic signed [65:0] prod_reg;
    logic               act_reg;
    logic [1:0]         k_reg;
    logic signed [49:0] tsum_reg;

    logic               out_valid_reg;
    logic               out_act_reg;
    logic signed [31:0] out_torque_reg;
    logic signed [31:0] out_margin_reg;
    logic               out_inenv_reg;
    logic               out_last_reg;

    logic in_acc, out_acc, trigger, out_free;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign trigger = in_acc && (mode == MODE_MEAS) && last_joint;
    assign out_free = !out_valid_reg || out_acc;

    // axis setup
    logic signed [31:0] mn, mx, sv, sc;
    logic [4:0]         n_cl;
    logic [3:0]         nm1;
    logic signed [32:0] m1, m2, mcand;
    logic               axis_ok;
    logic [31:0]        diff_u;
    logic [35:0]        num;

    always_comb
    begin
        mn = axis_min_reg[axis_reg];
        mx = axis_max_reg[axis_reg];
        sv = sched_reg[axis_jnt_reg[axis_reg]];
        if (axis_pts_reg[axis_reg] < 5'd2)
            n_cl = 5'd2;
        else if (axis_pts_reg[axis_reg] > 5'(MAX_POINTS))
            n_cl = 5'(MAX_POINTS);
        else
            n_cl = axis_pts_reg[axis_reg];
        nm1 = 4'(n_cl - 5'd1);
        m1 = 33'(sv) - 33'(mn);
        m2 = 33'(mx) - 33'(sv);
        mcand = (m1 < m2) ? m1 : m2;
        axis_ok = mx > mn;
        sc = (sv < mn) ? mn : ((sv > mx) ? mx : sv);
        diff_u = 32'(33'(sc) - 33'(mn));
        num = 36'(diff_u) * 36'(nm1);
    end

    // divider step
    logic [32:0] rem_sh;
    logic        qbit;
    logic [31:0] rem_new;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DIV_BITS-1]};
        qbit = rem_sh >= {1'b0, den_reg};
        rem_new = qbit ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
    end

    // cell result
    logic [3:0]  li, ncap;
    logic [19:0] fr_w;

    always_comb
    begin
        ncap = 4'(npts_reg[axis_reg] - 5'd2);
        li = (q_reg[19:16] > ncap) ? ncap : q_reg[19:16];
        fr_w = q_reg - {li, 16'h0000};
    end

    // corner weight factors and node base
    logic [16:0] f0, f1;
    logic [4:0]  rowi, coli;
    logic [7:0]  idx;
    logic [11:0] base_w;

    always_comb
    begin
        f0 = corner_reg[0] ? frac_reg[0] : 17'(ONE_Q16 - frac_reg[0]);
        f1 = corner_reg[1] ? frac_reg[1] : 17'(ONE_Q16 - frac_reg[1]);
        rowi = 5'(lo_reg[0]) + 5'(corner_reg[0]);
        coli = 5'(lo_reg[1]) + 5'(corner_reg[1]);
        idx = 8'(10'(rowi) * 10'(npts_reg[1]) + 10'(coli));
        base_w = {1'b0, idx, 3'b000} + {3'b000, idx, 1'b0};
    end

    // shared multiplier
    logic [3:0]         acc_idx;
    logic signed [50:0] acc_rd;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb
    begin
        case (state_reg)
            ST_TMUL: acc_idx = 4'({act_reg, k_reg});
            ST_TFIN: acc_idx = 4'(ERR_LEN * NUM_ACT) + 4'(act_reg);
            default: acc_idx = word_reg;
        endcase
        acc_rd = acc_reg[acc_idx];
        case (state_reg)
            ST_WGT:
            begin
                mul_a = {16'h0000, f1};
                mul_b = {16'h0000, f0};
            end
            ST_TMUL:
            begin
                mul_a = acc_rd[48:16];
                mul_b = 33'(err_reg[k_reg]);
            end
            default:
            begin
                mul_a = {16'h0000, w_reg};
                mul_b = 33'(rdata_reg);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // torque
    logic signed [50:0] tdiff;
    logic signed [31:0] tsat, msat;

    always_comb
    begin
        tdiff = 51'($signed(acc_rd[50:16])) - 51'(tsum_reg);
        if (tdiff > 51'sd2147483647)
            tsat = 32'sh7fffffff;
        else if (tdiff < -51'sd2147483648)
            tsat = 32'sh80000000;
        else
            tsat = tdiff[31:0];
        if (margin_reg > 33'sd2147483647)
            msat = 32'sh7fffffff;
        else if (margin_reg < -33'sd2147483648)
            msat = 32'sh80000000;
        else
            msat = margin_reg[31:0];
    end

    // error words
    logic signed [32:0] ep, ev;
    logic signed [31:0] ep_s, ev_s;

    always_comb
    begin
        ep = 33'(joint_position) - 33'(ref_position);
        ev = 33'(joint_velocity) - 33'(ref_velocity);
        ep_s = (ep[32] != ep[31]) ? (ep[32] ? 32'sh80000000 : 32'sh7fffffff) : ep[31:0];
        ev_s = (ev[32] != ev[31]) ? (ev[32] ? 32'sh80000000 : 32'sh7fffffff) : ev[31:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (trigger) state_next = ST_AXIS;
            ST_AXIS:   state_next = axis_ok ? ST_DIV : (axis_reg ? ST_WGT : ST_AXIS);
            ST_DIV:    if (cnt_reg == 6'd0) state_next = ST_DIVEND;
            ST_DIVEND: state_next = axis_reg ? ST_WGT : ST_AXIS;
            ST_WGT:    state_next = ST_BASE;
            ST_BASE:   state_next = ST_RD;
            ST_RD:     state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:
            begin
                if (word_reg != 4'(NODE_WORDS - 1))
                    state_next = ST_RD;
                else if (corner_reg != 2'd3)
                    state_next = ST_WGT;
                else
                    state_next = ST_TMUL;
            end
            ST_TMUL:   state_next = ST_TACC;
            ST_TACC:   state_next = (k_reg == 2'(ERR_LEN - 1)) ? ST_TFIN : ST_TMUL;
            ST_TFIN:
            begin
                if (out_free)
                    state_next = (act_reg == 1'(NUM_ACT - 1)) ? ST_IDLE : ST_TMUL;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall        = state_reg != ST_IDLE;
        out_valid       = out_valid_reg;
        actuator_index  = out_act_reg;
        torque          = out_torque_reg;
        envelope_margin = out_margin_reg;
        in_envelope     = out_inenv_reg;
        last_actuator   = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < 2; d++)
            begin
                axis_min_reg[d] <= -32'sd65536;
                axis_max_reg[d] <= 32'sd65536;
                axis_pts_reg[d] <= 5'd2;
                axis_jnt_reg[d] <= 1'(d);
                sched_reg[d]    <= '0;
            end
            for (int k = 0; k < ERR_LEN; k++)
                err_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index[1:0])
                    FLD_MIN:    axis_min_reg[cfg_index[2]] <= cfg_data;
                    FLD_MAX:    axis_max_reg[cfg_index[2]] <= cfg_data;
                    FLD_POINTS: axis_pts_reg[cfg_index[2]] <= cfg_data[4:0];
                    FLD_JOINT:  axis_jnt_reg[cfg_index[2]] <= cfg_data[0];
                    default:    axis_jnt_reg[cfg_index[2]] <= cfg_data[0];
                endcase
            end
            if (in_acc && mode == MODE_MEAS)
            begin
                sched_reg[joint_index]     <= joint_position;
                err_reg[joint_index]       <= ep_s;
                err_reg[2 + joint_index]   <= ev_s;
            end
            if (state_reg == ST_TFIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (in_acc && mode == MODE_TABLE && table_address < 12'(GAIN_DEPTH))
            gain_mem[table_address] <= table_value;
        if (state_reg == ST_RD)
            rdata_reg <= gain_mem[base_reg + 12'(word_reg)];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                axis_reg <= 1'b0;
                corner_reg <= 2'd0;
                act_reg <= 1'b0;
                k_reg <= 2'd0;
                tsum_reg <= '0;
                for (int i = 0; i < NODE_WORDS; i++)
                    acc_reg[i] <= '0;
            end
            ST_AXIS:
            begin
                npts_reg[axis_reg] <= n_cl;
                if (!axis_reg || mcand < margin_reg)
                    margin_reg <= mcand;
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= 6'(DIV_BITS - 1);
                dvd_reg <= {num, 16'h0000};
                den_reg <= 32'(33'(mx) - 33'(mn));
                if (!axis_ok)
                begin
                    lo_reg[axis_reg]   <= '0;
                    frac_reg[axis_reg] <= '0;
                    axis_reg <= 1'b1;
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_new;
                q_reg   <= {q_reg[18:0], qbit};
                dvd_reg <= {dvd_reg[DIV_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_DIVEND:
            begin
                lo_reg[axis_reg]   <= li;
                frac_reg[axis_reg] <= fr_w[16:0];
                axis_reg <= 1'b1;
            end
            ST_WGT:
                prod_reg <= mul_p;
            ST_BASE:
            begin
                w_reg    <= prod_reg[32:16];
                base_reg <= base_w;
                word_reg <= 4'd0;
            end
            ST_MUL:
                prod_reg <= mul_p;
            ST_ACC:
            begin
                acc_reg[word_reg] <= acc_rd + prod_reg[50:0];
                word_reg <= word_reg + 4'd1;
                if (word_reg == 4'(NODE_WORDS - 1))
                    corner_reg <= corner_reg + 2'd1;
            end
            ST_TMUL:
                prod_reg <= mul_p;
            ST_TACC:
            begin
                tsum_reg <= tsum_reg + prod_reg[65:16];
                k_reg <= k_reg + 2'd1;
            end
            ST_TFIN:
            begin
                if (out_free)
                begin
                    out_act_reg    <= act_reg;
                    out_torque_reg <= tsat;
                    out_margin_reg <= msat;
                    out_inenv_reg  <= !margin_reg[32];
                    out_last_reg   <= act_reg == 1'(NUM_ACT - 1);
                    act_reg  <= act_reg + 1'b1;
                    tsum_reg <= '0;
                    k_reg    <= 2'd0;
                end
            end
            default:
                prod_reg <= prod_reg;
        endcase
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 6'd0) |=> (state_reg == ST_DIVEND))
        else $error("division did not end");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_actuator) |-> (actuator_index == 1'(NUM_ACT - 1)))
        else $error("last beat on wrong actuator");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WGT) |-> (frac_reg[0] <= ONE_Q16 && frac_reg[1] <= ONE_Q16))
        else $error("fraction above one");

endmodule

// ===== dv/gain_scheduled_state_feedback_checker.sv =====
// checker for the gain-scheduled state-feedback block: tracks register writes,
// table loads and measurement beats, predicts each torque beat and compares them
// depends on gssf_pkg

module gain_scheduled_state_feedback_checker
    import gssf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               mode,
    input  logic [11:0]        table_address,
    input  logic signed [31:0] table_value,
    input  logic               joint_index,
    input  logic signed [31:0] joint_position,
    input  logic signed [31:0] joint_velocity,
    input  logic signed [31:0] ref_position,
    input  logic signed [31:0] ref_velocity,
    input  logic               last_joint,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               actuator_index,
    input  logic signed [31:0] torque,
    input  logic signed [31:0] envelope_margin,
    input  logic               in_envelope,
    input  logic               last_actuator,
    output int                 fail_count,
    output int                 pending,
    output int                 beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               act;
        logic signed [31:0] trq;
        logic signed [31:0] margin;
        logic               inside_env;
        logic               last;
    } torque_beat_t;

    torque_beat_t torque_q[$];

    logic signed [31:0] gain_mem [GAIN_DEPTH];
    logic signed [31:0] err_vec [ERR_LEN];
    logic signed [31:0] sched_pos [2];
    logic signed [31:0] ax_min [2];
    logic signed [31:0] ax_max [2];
    logic [4:0]         ax_pts [2];
    logic               ax_jnt [2];

    function automatic longint sat32(longint x);
        if (x > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
        if (x < -longint'(64'h80000000)) return -longint'(64'h80000000);
        return x;
    endfunction

    task automatic predict_torques();
        longint lo [2];
        longint frac [2];
        longint npts [2];
        longint kacc [NUM_ACT][ERR_LEN];
        longint uacc [NUM_ACT];
        longint margin;
        longint n, mn, mx, sv, sc, w, f, idx, stride, sum, t;
        longint unsigned num, pos;
        int bit_c;
        torque_beat_t b;
        margin = 64'sh7FFFFFFFFFFFFFFF;
        for (int d = 0; d < 2; d++)
        begin
            n = ax_pts[d];
            if (n < 2) n = 2;
            if (n > MAX_POINTS) n = MAX_POINTS;
            npts[d] = n;
            mn = ax_min[d];
            mx = ax_max[d];
            sv = sched_pos[ax_jnt[d]];
            lo[d] = 0;
            frac[d] = 0;
            if (sv - mn < margin) margin = sv - mn;
            if (mx - sv < margin) margin = mx - sv;
            if (mx > mn)
            begin
                sc = sv < mn ? mn : (sv > mx ? mx : sv);
                num = longint'(sc - mn) * longint'(n - 1);
                pos = (num << 16) / longint'(mx - mn);
                lo[d] = longint'(pos >> 16);
                if (lo[d] > n - 2) lo[d] = n - 2;
                frac[d] = longint'(pos) - lo[d] * 65536;
            end
        end
        for (int a = 0; a < NUM_ACT; a++)
        begin
            uacc[a] = 0;
            for (int k = 0; k < ERR_LEN; k++) kacc[a][k] = 0;
        end
        for (int c = 0; c < 4; c++)
        begin
            w = 65536;
            idx = 0;
            stride = 1;
            for (int d = 1; d >= 0; d--)
            begin
                bit_c = (c >> d) & 1;
                f = bit_c ? frac[d] : 65536 - frac[d];
                w = (w * f) >>> 16;
                idx += (lo[d] + bit_c) * stride;
                stride *= npts[d];
            end
            idx = idx * NODE_WORDS;
            for (int a = 0; a < NUM_ACT; a++)
            begin
                for (int k = 0; k < ERR_LEN; k++)
                    kacc[a][k] += w * longint'(gain_mem[idx + a * ERR_LEN + k]);
                uacc[a] += w * longint'(gain_mem[idx + NUM_ACT * ERR_LEN + a]);
            end
        end
        for (int a = 0; a < NUM_ACT; a++)
        begin
            sum = 0;
            for (int k = 0; k < ERR_LEN; k++)
                sum += ((kacc[a][k] >>> 16) * longint'(err_vec[k])) >>> 16;
            t = sat32((uacc[a] >>> 16) - sum);
            b.act = a[0];
            b.trq = t[31:0];
            b.margin = 32'(sat32(margin));
            b.inside_env = margin >= 0;
            b.last = (a == NUM_ACT - 1);
            torque_q.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        torque_beat_t exp_b;
        longint ev;
        int errs;
        if (!rst_n)
        begin
            torque_q.delete();
            for (int k = 0; k < ERR_LEN; k++) err_vec[k] = '0;
            for (int d = 0; d < 2; d++)
            begin
                sched_pos[d] = '0;
                ax_min[d] = -32'sd65536;
                ax_max[d] = 32'sd65536;
                ax_pts[d] = 5'd2;
                ax_jnt[d] = d[0];
            end
            fail_count <= 0;
            pending <= 0;
            beats_checked <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_write)
            begin
                case (cfg_index[1:0])
                    FLD_MIN:    ax_min[cfg_index[2]] = cfg_data;
                    FLD_MAX:    ax_max[cfg_index[2]] = cfg_data;
                    FLD_POINTS: ax_pts[cfg_index[2]] = cfg_data[4:0];
                    FLD_JOINT:  ax_jnt[cfg_index[2]] = cfg_data[0];
                    default:    ax_jnt[cfg_index[2]] = cfg_data[0];
                endcase
            end
            if (out_valid && !out_stall)
            begin
                beats_checked <= beats_checked + 1;
                if (torque_q.size() == 0)
                begin
                    $error("torque beat with nothing expected");
                    errs++;
                end
                else
                begin
                    exp_b = torque_q.pop_front();
                    if (actuator_index !== exp_b.act)
                    begin
                        $error("actuator_index exp %0d got %0d", exp_b.act, actuator_index);
                        errs++;
                    end
                    if (torque !== exp_b.trq)
                    begin
                        $error("torque exp %0d got %0d", exp_b.trq, torque);
                        errs++;
                    end
                    if (envelope_margin !== exp_b.margin)
                    begin
                        $error("envelope_margin exp %0d got %0d", exp_b.margin,
                               envelope_margin);
                        errs++;
                    end
                    if (in_envelope !== exp_b.inside_env)
                    begin
                        $error("in_envelope exp %0d got %0d", exp_b.inside_env, in_envelope);
                        errs++;
                    end
                    if (last_actuator !== exp_b.last)
                    begin
                        $error("last_actuator exp %0d got %0d", exp_b.last, last_actuator);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_TABLE)
                begin
                    if (table_address < GAIN_DEPTH) gain_mem[table_address] = table_value;
                end
                else
                begin
                    sched_pos[joint_index] = joint_position;
                    ev = sat32(longint'(joint_position) - longint'(ref_position));
                    err_vec[joint_index] = ev[31:0];
                    ev = sat32(longint'(joint_velocity) - longint'(ref_velocity));
                    err_vec[2 + joint_index] = ev[31:0];
                    if (last_joint) predict_torques();
                end
            end
            fail_count <= fail_count + errs;
            pending <= torque_q.size();
        end
    end

endmodule

// ===== dv/gain_scheduled_state_feedback_top_test.sv =====
// testbench top for gain_scheduled_state_feedback_top: loads the gain table nodes in use,
// runs directed and random joint steps over several grid settings, gives the verdict
// depends on gssf_pkg, the block and gain_scheduled_state_feedback_checker

module gain_scheduled_state_feedback_top_test;
    import gssf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               mode = MODE_TABLE;
    logic [11:0]        table_address = '0;
    logic signed [31:0] table_value = '0;
    logic               joint_index = 1'b0;
    logic signed [31:0] joint_position = '0;
    logic signed [31:0] joint_velocity = '0;
    logic signed [31:0] ref_position = '0;
    logic signed [31:0] ref_velocity = '0;
    logic               last_joint = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               actuator_index;
    logic signed [31:0] torque;
    logic signed [31:0] envelope_margin;
    logic               in_envelope;
    logic               last_actuator;
    int                 fail_count;
    int                 pending;
    int                 beats_checked;
    logic               quiet = 1'b0;
    int                 stall_hold = 0;
    int                 phases = 0;

    always #6 clk = ~clk;

    gain_scheduled_state_feedback_top DUT (.*);

    gain_scheduled_state_feedback_checker u_checker (.*);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_hold <= 0;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else if (!out_stall && $urandom_range(0, 1))
        begin
            out_stall <= 1'b1;
            stall_hold <= $urandom_range(0, 12);
        end
        else
        begin
            out_stall <= 1'b0;
            stall_hold <= $urandom_range(0, 30);
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
        endcase
    endfunction

    function automatic logic [31:0] gain_word();
        if ($urandom_range(0, 63) == 0) return $urandom;
        return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    endfunction

    task automatic send_beat(input logic m, input logic [11:0] addr, input logic [31:0] val,
                             input logic j, input logic [31:0] jp, input logic [31:0] jv,
                             input logic [31:0] rp, input logic [31:0] rv, input logic lj);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        table_address <= addr;
        table_value <= val;
        joint_index <= j;
        joint_position <= jp;
        joint_velocity <= jv;
        ref_position <= rp;
        ref_velocity <= rv;
        last_joint <= lj;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic meas(input logic j, input logic [31:0] jp, input logic lj);
        send_beat(MODE_MEAS, 12'($urandom), $urandom, j, jp, pick_word(), pick_word(),
                  pick_word(), lj);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_axis(input logic ax, input logic [31:0] mn, input logic [31:0] mx,
                            input logic [31:0] pts, input logic [31:0] jnt);
        logic [1:0] fld [4];
        logic [31:0] val [4];
        fld = '{FLD_MIN, FLD_MAX, FLD_POINTS, FLD_JOINT};
        val = '{mn, mx, pts, jnt};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= {ax, fld[i]};
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
        phases++;
    endtask

    task automatic random_steps(input int count);
        int r;
        logic j;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 9);
            j = 1'($urandom_range(0, 1));
            if (r == 0)
                send_beat(MODE_TABLE, 12'($urandom), gain_word(), j, $urandom, $urandom,
                          $urandom, $urandom, 1'($urandom_range(0, 1)));
            else if (r == 1)
                meas(j, pick_word(), 1'($urandom_range(0, 1)));
            else
            begin
                meas(j, pick_word(), 1'b0);
                meas(!j, pick_word(), 1'b1);
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_axis(1'b0, -32'sd65536, 32'sd65536, 2, 0);
        set_axis(1'b1, -32'sd65536, 32'sd65536, 2, 1);

        // every grid below uses at most 32 nodes
        for (int a = 0; a < 32 * NODE_WORDS; a++)
            send_beat(MODE_TABLE, a[11:0], gain_word(), a[0], '0, '0, '0, '0, a[1]);
        send_beat(MODE_TABLE, 12'd2560, 32'h7FFFFFFF, 1'b0, '0, '0, '0, '0, 1'b0);
        send_beat(MODE_TABLE, 12'hFFF, 32'h80000000, 1'b1, '1, '1, '1, '1, 1'b1);

        send_beat(MODE_MEAS, '0, '0, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 1'b0);
        send_beat(MODE_MEAS, '0, '0, 1'b1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 1'b1);
        meas(1'b0, -32'sd65536, 1'b0);
        meas(1'b1, 32'sd65536, 1'b1);
        meas(1'b0, 32'sd0, 1'b0);
        meas(1'b1, 32'sd32768, 1'b1);
        meas(1'b1, 32'sd70000, 1'b1);
        meas(1'b0, -32'sd70000, 1'b1);
        meas(1'b0, 32'sd12345, 1'b0);
        random_steps(15);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        random_steps(10);
        settle();

        set_axis(1'b0, 32'h80000000, 32'h7FFFFFFF, 8, 1);
        set_axis(1'b1, -32'sd1048576, 32'sd1048576, 4, 0);
        meas(1'b0, 32'h80000000, 1'b0);
        meas(1'b1, 32'h7FFFFFFF, 1'b1);
        random_steps(25);
        settle();

        set_axis(1'b0, 32'sd65536, 32'sd65536, 0, 0);
        set_axis(1'b1, 32'sd262144, -32'sd262144, 31, 0);
        meas(1'b0, 32'sd65536, 1'b1);
        random_steps(15);
        settle();

        set_axis(1'b0, -32'sd131072, 32'sd196608, 1, 1);
        set_axis(1'b1, 32'sd0, 32'sd458752, 16, 0);
        quiet <= 1'b1;
        random_steps(25);
        settle();

        $display("checked %0d torque beats over %0d register settings, used table nodes loaded",
                 beats_checked, phases);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(12ns * 3_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
